// ----- design/tlvts_pkg.sv -----
// Package for the TLV tag search unit: field widths, header codes,
// the header phase type and the result word. No dependencies.
`default_nettype none
package tlvts_pkg;

   localparam int BYTE_W = 8;
   localparam int TAG_W  = 16;
   localparam int LEN_W  = 16;
   localparam int HDR_W  = 24;

   localparam logic [4:0]        TAG_EXT_CODE = 5'h1f;
   localparam logic [BYTE_W-1:0] LEN_EXT_CODE = 8'hff;
   localparam logic [LEN_W-1:0]  OFFSET_SAT   = 16'hffff;
   localparam int                COMP_BIT_LO  = 5;
   localparam int                COMP_BIT_HI  = 13;

   typedef enum logic [2:0] {
      PH_TAG1  = 3'd0,
      PH_TAG2  = 3'd1,
      PH_LEN   = 3'd2,
      PH_LENHI = 3'd3,
      PH_LENLO = 3'd4,
      PH_SKIP  = 3'd5
   } phase_type;

   typedef struct packed {
      logic             found;
      logic [LEN_W-1:0] value_offset;
      logic [LEN_W-1:0] value_length;
      logic             matched_composite;
   } rsp_word_type;

endpackage
`default_nettype wire

// ----- design/tlvts_intf.sv -----
// Valid/ready channel interfaces for the TLV tag search unit.
// The request channel carries buffer bytes, the response channel results.
`default_nettype none
interface tlvts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface tlvts_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [15:0] value_offset;
   logic [15:0] value_length;
   logic        matched_composite;

   modport source (output valid, found, value_offset, value_length, matched_composite,
                   input ready);
   modport sink (input valid, found, value_offset, value_length, matched_composite,
                 output ready);
endinterface
`default_nettype wire

// ----- design/tlvts_rsp_buf.sv -----
// Two-entry result buffer: an output register plus a skid entry.
// Depends on tlvts_pkg for the result word type.
`default_nettype none
module tlvts_rsp_buf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  wire tlvts_pkg::rsp_word_type in_word,
   output logic                   in_ready,
   output logic                   out_valid,
   output tlvts_pkg::rsp_word_type out_word,
   input  wire                    out_ready
);
   import tlvts_pkg::*;

   rsp_word_type main_ff, main_in, skid_ff, skid_in;
   logic         main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   logic         in_fire, out_fire;

   assign in_ready  = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_word  = main_ff;
   assign in_fire   = in_valid & in_ready;
   assign out_fire  = main_v_ff & out_ready;

   always_comb begin
      main_in   = main_ff;
      skid_in   = skid_ff;
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      if (out_fire) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else if (in_fire) begin
            main_in = in_word;
         end else begin
            main_v_in = 1'b0;
         end
      end else if (in_fire) begin
         if (main_v_ff) begin
            skid_in   = in_word;
            skid_v_in = 1'b1;
         end else begin
            main_in   = in_word;
            main_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid entry holds a word while the output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(main_v_ff && !out_ready))
      else $error("skid entry filled although the output register was draining");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      out_fire && !skid_v_ff && !in_fire |=> !main_v_ff)
      else $error("output register still valid after its only word was taken");

endmodule
`default_nettype wire

// ----- design/tlv_tag_search_unit.sv -----
// Top level of the TLV tag search unit: header parser, level stack and
// result generation. Depends on tlvts_pkg, tlvts_intf and tlvts_rsp_buf.
//
// The unit takes a TLV buffer one word (one byte) per cycle on req_bus while
// req_bus is ready, and searches it for the tag held in the csr register.
// The user must write it with csr_wr_en/csr_wr_data only while no search
// is in flight; the block itself does not enforce this. A word flagged
// first_byte starts a new search; last_byte marks the end of the buffer.
// Each search yields at most one result word on rsp_bus: found with the
// value offset, length and composite flag, or not-found when the buffer
// ends with no pending composite match or a top-level header is
// unsupported. Words after the result and before the next first_byte are
// accepted and ignored. Every accepted word is fully processed in the
// cycle it is taken, and its result is registered in the output buffer
// before it appears on rsp_bus. Results pass through a two-entry output
// buffer, so req_bus stays ready while one result waits on a stalled
// receiver, and drops ready only while both entries are occupied.
// After reset the unit is idle with a target tag of zero.
`default_nettype none
module tlv_tag_search_unit #(
   parameter int MAX_DEPTH        = 8,
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_wr_en,
   input  wire [15:0]   csr_wr_data,
   tlvts_req_if.sink    req_bus,
   tlvts_rsp_if.source  rsp_bus
);
   import tlvts_pkg::*;

   localparam int NL = MAX_DEPTH + 1;
   localparam int LW = $clog2(NL);
   localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int OW = LEN_W + 1;

   logic [TAG_W-1:0]  target_ff;
   logic [LEN_W-1:0]  rem_ff [NL];
   logic [LEN_W-1:0]  rem_in [NL];
   logic [LEN_W-1:0]  poff_ff [NL];
   logic [LEN_W-1:0]  plen_ff [NL];
   logic [NL-1:0]     pend_ff, pend_in, aband_ff, aband_in;
   phase_type         phase_ff, phase_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic [LW-1:0]     level_ff, level_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              done_ff, done_in;

   logic              req_fire, clr, buf_ready;
   logic [NL-1:0]     s_pend, s_aband;
   logic [LW-1:0]     s_level, level_nx, hp, lvl_t, tgt;
   phase_type         s_phase;
   logic [HDR_W-1:0]  s_hdr;
   logic [PW-1:0]     s_pos;
   logic              s_done;
   logic [LEN_W-1:0]  rem_cur, rl, clen, hlen, voff;
   logic [OW-1:0]     voff_full;
   logic [TAG_W-1:0]  tag;
   logic              comp;
   logic [BYTE_W-1:0] b;
   logic              ab, hd, desc, mt, pop, eob, use_pend;
   logic [NL-1:0]     rem_zero, rem_one;
   logic              rsp_push;
   rsp_word_type      rsp_word, out_word;
   logic              out_valid;

   assign req_fire = req_bus.valid & req_bus.ready;
   assign clr      = req_fire & req_bus.first_byte;
   assign b        = req_bus.data_byte;

   assign s_pend   = clr ? '0 : pend_ff;
   assign s_aband  = clr ? '0 : aband_ff;
   assign s_level  = clr ? '0 : level_ff;
   assign s_phase  = clr ? PH_TAG1 : phase_ff;
   assign s_hdr    = clr ? '0 : hdr_ff;
   assign s_pos    = clr ? '0 : pos_ff;
   assign s_done   = clr ? 1'b0 : done_ff;
   assign rem_cur  = rem_ff[s_level];
   assign level_nx = s_level + LW'(1);

   assign tag       = s_hdr[HDR_W-1:BYTE_W];
   assign comp      = (tag[TAG_W-1:BYTE_W] != '0) ? tag[COMP_BIT_HI] : tag[COMP_BIT_LO];
   assign voff_full = OW'(s_pos) + OW'(1);
   assign voff      = voff_full[OW-1] ? OFFSET_SAT : voff_full[LEN_W-1:0];

   always_comb begin
      hp = '0;
      for (int k = 0; k < NL; k++) begin
         if (pend_ff[k]) begin
            hp = LW'(k);
         end
      end
   end

   always_comb begin
      phase_in = s_phase;
      hdr_in   = s_hdr;
      level_in = s_level;
      pos_in   = s_pos;
      pend_in  = s_pend;
      aband_in = s_aband;
      rl       = rem_cur;
      clen     = '0;
      hlen     = '0;
      ab       = 1'b0;
      hd       = 1'b0;
      desc     = 1'b0;
      mt       = 1'b0;
      pop      = 1'b0;
      eob      = 1'b0;
      use_pend = 1'b0;
      rsp_push = 1'b0;
      rsp_word = '0;
      lvl_t    = '0;
      tgt      = '0;
      rem_zero = '0;
      rem_one  = '0;

      if (req_fire && !s_done) begin
         if (s_pos >= PW'(MAX_BUFFER_BYTES)) begin
            eob = 1'b1;
         end else begin
            if (s_level != '0 && rl != '0) begin
               rl = rl - LEN_W'(1);
            end
            // An abandoned level only counts down its remaining bytes.
            if (!(s_level != '0 && s_aband[s_level])) begin
               case (s_phase)
                  PH_TAG2: begin
                     if (b[4:0] == TAG_EXT_CODE) begin
                        ab = 1'b1;
                     end else begin
                        hdr_in[15:8] = s_hdr[15:8] | {1'b0, b[6:0]};
                        phase_in     = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     if (b == LEN_EXT_CODE) begin
                        phase_in = PH_LENHI;
                        if (s_level != '0 && rl[LEN_W-1:1] == '0) begin
                           ab = 1'b1;
                        end
                     end else begin
                        hd   = 1'b1;
                        hlen = LEN_W'(b);
                     end
                  end
                  PH_LENHI: begin
                     hdr_in[7:0] = b;
                     phase_in    = PH_LENLO;
                  end
                  PH_LENLO: begin
                     hd   = 1'b1;
                     hlen = {s_hdr[7:0], b};
                  end
                  PH_SKIP: begin
                     hdr_in = s_hdr - HDR_W'(1);
                     if (hdr_in == '0) begin
                        phase_in = PH_TAG1;
                     end
                  end
                  default: begin
                     if (b[4:0] == TAG_EXT_CODE) begin
                        hdr_in   = {b, 16'h0000};
                        phase_in = PH_TAG2;
                        if (s_level != '0 && rl[LEN_W-1:1] == '0) begin
                           ab = 1'b1;
                        end
                     end else begin
                        hdr_in   = {8'h00, b, 8'h00};
                        phase_in = PH_LEN;
                     end
                  end
               endcase
            end

            if (hd) begin
               if (comp && s_level < LW'(MAX_DEPTH)) begin
                  clen = hlen;
                  if (s_level != '0) begin
                     if (hlen > rl) begin
                        clen = rl;
                     end
                     rl = rl - clen;
                  end
                  desc               = 1'b1;
                  mt                 = (tag == target_ff);
                  level_in           = level_nx;
                  phase_in           = PH_TAG1;
                  pend_in[level_nx]  = mt;
                  aband_in[level_nx] = 1'b0;
               end else if (tag == target_ff) begin
                  rsp_push                   = 1'b1;
                  rsp_word.found             = 1'b1;
                  rsp_word.value_offset      = voff;
                  rsp_word.value_length      = hlen;
                  rsp_word.matched_composite = comp;
               end else if (s_level != '0 && hlen > rl) begin
                  ab = 1'b1;
               end else if (hlen == '0) begin
                  phase_in = PH_TAG1;
               end else begin
                  hdr_in   = HDR_W'(hlen);
                  phase_in = PH_SKIP;
               end
            end

            if (ab) begin
               if (s_level == '0) begin
                  rsp_push = 1'b1;
               end else begin
                  aband_in[s_level] = 1'b1;
                  if (s_pend[s_level]) begin
                     rsp_push = 1'b1;
                     use_pend = 1'b1;
                  end
               end
            end

            pos_in = s_pos + PW'(1);
         end
      end

      for (int k = 0; k < NL; k++) begin
         rem_in[k] = rem_ff[k];
         if (LW'(k) == s_level) begin
            rem_in[k] = rl;
         end
         if (desc && LW'(k) == level_nx) begin
            rem_in[k] = clen;
         end
         rem_zero[k] = (rem_in[k] == '0);
         rem_one[k]  = (rem_in[k] == LEN_W'(1));
      end

      // Close out exhausted levels: pop down to the innermost parent that
      // still has bytes or a pending composite match.
      lvl_t = level_in;
      for (int k = 1; k < NL; k++) begin
         if (LW'(k) < lvl_t && (pend_in[k] || !rem_zero[k])) begin
            tgt = LW'(k);
         end
      end

      if (req_fire && !s_done && !eob && !rsp_push && lvl_t != '0) begin
         if (aband_in[lvl_t]) begin
            pop = rem_zero[lvl_t];
         end else if (phase_in == PH_TAG1 && (rem_zero[lvl_t] || rem_one[lvl_t])) begin
            if (pend_in[lvl_t]) begin
               rsp_push = 1'b1;
               use_pend = 1'b1;
            end else if (rem_one[lvl_t]) begin
               aband_in[lvl_t] = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end
         if (pop) begin
            pend_in[lvl_t]  = 1'b0;
            aband_in[lvl_t] = 1'b0;
            level_in        = tgt;
            phase_in        = PH_TAG1;
            if (tgt != '0) begin
               if (pend_in[tgt] && (rem_zero[tgt] || rem_one[tgt])) begin
                  rsp_push = 1'b1;
                  use_pend = 1'b1;
               end else if (rem_one[tgt]) begin
                  aband_in[tgt] = 1'b1;
               end
            end
         end
      end

      if (req_fire && !s_done && !rsp_push && (eob || req_bus.last_byte)) begin
         rsp_push = 1'b1;
         use_pend = |pend_in;
      end

      // The innermost pending composite is either the one opened by this
      // word or the highest stored one.
      if (use_pend) begin
         rsp_word.found             = 1'b1;
         rsp_word.matched_composite = 1'b1;
         if (desc && mt) begin
            rsp_word.value_offset = voff;
            rsp_word.value_length = hlen;
         end else begin
            rsp_word.value_offset = poff_ff[hp];
            rsp_word.value_length = plen_ff[hp];
         end
      end

      done_in = s_done | rsp_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         pend_ff   <= '0;
         aband_ff  <= '0;
         phase_ff  <= PH_TAG1;
         hdr_ff    <= '0;
         level_ff  <= '0;
         pos_ff    <= '0;
         done_ff   <= 1'b1;
         for (int k = 0; k < NL; k++) begin
            rem_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         if (req_fire) begin
            pend_ff  <= pend_in;
            aband_ff <= aband_in;
            phase_ff <= phase_in;
            hdr_ff   <= hdr_in;
            level_ff <= level_in;
            pos_ff   <= pos_in;
            done_ff  <= done_in;
            for (int k = 0; k < NL; k++) begin
               rem_ff[k] <= rem_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (desc) begin
         poff_ff[level_nx] <= voff;
         plen_ff[level_nx] <= hlen;
      end
   end

   tlvts_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rsp_push),
      .in_word   (rsp_word),
      .in_ready  (buf_ready),
      .out_valid (out_valid),
      .out_word  (out_word),
      .out_ready (rsp_bus.ready)
   );

   assign req_bus.ready             = buf_ready;
   assign rsp_bus.valid             = out_valid;
   assign rsp_bus.found             = out_word.found;
   assign rsp_bus.value_offset      = out_word.value_offset;
   assign rsp_bus.value_length      = out_word.value_length;
   assign rsp_bus.matched_composite = out_word.matched_composite;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(MAX_DEPTH))
      else $error("nesting level beyond the maximum depth");

   a_no_pending_above: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> ((pend_ff >> level_ff) >> 1) == '0)
      else $error("pending match recorded above the current level");

   a_result_ends_search: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> done_ff && rsp_bus.valid)
      else $error("result produced but search not closed or result not presented");

endmodule
`default_nettype wire

// ----- bench/tlv_tag_search_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for tlv_tag_search_unit: directed and random TLV buffers,
// a built-in match predictor and randomized valid/ready stalls on both channels.
// Depends on tlvts_pkg, tlvts_intf and the tlv_tag_search_unit RTL.
module tlv_tag_search_unit_tb;
   import tlvts_pkg::*;

   localparam int DEPTH_LIMIT  = 8;
   localparam int BUFFER_LIMIT = 65536;
   localparam int RANDOM_WORDS = 1950;

   typedef logic [7:0] byte_queue_type [$];
   typedef enum int {
      FRAME_CLEAN,
      FRAME_CUT,
      FRAME_OPEN,
      FRAME_RESTART,
      FRAME_TRAIL
   } frame_kind_type;

   class tlv_match_tracker;
      logic [15:0]  target;
      logic [16:0]  level_left [0:DEPTH_LIMIT];
      bit           level_dropped [0:DEPTH_LIMIT];
      bit           held [0:DEPTH_LIMIT];
      logic [15:0]  held_offset [0:DEPTH_LIMIT];
      logic [15:0]  held_length [0:DEPTH_LIMIT];
      phase_type    phase;
      logic [23:0]  header;
      int           level;
      logic [16:0]  position;
      bit           done;
      rsp_word_type awaited_matches [$];
      int           mismatches;

      function new();
         clear();
         target = '0;
         done = 1'b1;
         mismatches = 0;
      endfunction

      function void clear();
         foreach (level_left[i]) begin
            level_left[i] = '0;
            level_dropped[i] = 1'b0;
            held[i] = 1'b0;
            held_offset[i] = '0;
            held_length[i] = '0;
         end
         phase = PH_TAG1;
         header = '0;
         level = 0;
         position = '0;
      endfunction

      function void post_match(bit found, logic [15:0] offset, logic [15:0] length, bit comp);
         rsp_word_type w;
         w.found = found;
         w.value_offset = offset;
         w.value_length = length;
         w.matched_composite = comp;
         awaited_matches.push_back(w);
         done = 1'b1;
      endfunction

      function void drop_level();
         if (level == 0) begin
            post_match(1'b0, '0, '0, 1'b0);
         end else begin
            level_dropped[level] = 1'b1;
            if (held[level]) post_match(1'b1, held_offset[level], held_length[level], 1'b1);
         end
      endfunction

      function void close_buffer();
         for (int l = level; l > 0; l--) begin
            if (held[l]) begin
               post_match(1'b1, held_offset[l], held_length[l], 1'b1);
               return;
            end
         end
         post_match(1'b0, '0, '0, 1'b0);
      endfunction

      function void header_done(logic [15:0] len);
         logic [15:0] tag;
         logic [16:0] voff;
         logic [16:0] clen;
         bit          comp;
         tag = header[23:8];
         comp = (tag > 16'h00ff) ? tag[COMP_BIT_HI] : tag[COMP_BIT_LO];
         voff = position + 17'd1;
         if (voff > 17'h0ffff) voff = {1'b0, OFFSET_SAT};
         if (comp && level < DEPTH_LIMIT) begin
            clen = {1'b0, len};
            if (level > 0) begin
               if (clen > level_left[level]) clen = level_left[level];
               level_left[level] -= clen;
            end
            level++;
            level_left[level] = clen;
            level_dropped[level] = 1'b0;
            held[level] = (tag == target);
            held_offset[level] = voff[15:0];
            held_length[level] = len;
            phase = PH_TAG1;
         end else if (tag == target) begin
            post_match(1'b1, voff[15:0], len, comp);
         end else if (level > 0 && {1'b0, len} > level_left[level]) begin
            drop_level();
         end else if (len == 16'h0000) begin
            phase = PH_TAG1;
         end else begin
            header = {8'h00, len};
            phase = PH_SKIP;
         end
      endfunction

      function void take_byte(logic [7:0] b, bit first, bit last);
         if (first) begin
            clear();
            done = 1'b0;
         end
         if (done) return;
         if (position >= BUFFER_LIMIT) begin
            close_buffer();
            return;
         end
         if (level > 0 && level_left[level] != 0) level_left[level]--;
         if (!(level > 0 && level_dropped[level])) begin
            case (phase)
               PH_TAG2: begin
                  if (b[4:0] == TAG_EXT_CODE) begin
                     drop_level();
                  end else begin
                     header[15:8] = {1'b0, b[6:0]};
                     phase = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (b == LEN_EXT_CODE) begin
                     phase = PH_LENHI;
                     if (level > 0 && level_left[level] < 2) drop_level();
                  end else begin
                     header_done({8'h00, b});
                  end
               end
               PH_LENHI: begin
                  header[7:0] = b;
                  phase = PH_LENLO;
               end
               PH_LENLO: header_done({header[7:0], b});
               PH_SKIP: begin
                  header = header - 24'd1;
                  if (header == 24'd0) phase = PH_TAG1;
               end
               default: begin
                  if (b[4:0] == TAG_EXT_CODE) begin
                     header = {b, 16'h0000};
                     phase = PH_TAG2;
                     if (level > 0 && level_left[level] < 2) drop_level();
                  end else begin
                     header = {8'h00, b, 8'h00};
                     phase = PH_LEN;
                  end
               end
            endcase
         end
         // Unwind levels that are used up or were abandoned and have drained.
         while (!done && level > 0) begin
            if (level_dropped[level]) begin
               if (level_left[level] != 0) break;
            end else if (phase == PH_TAG1 && level_left[level] < 2) begin
               if (held[level]) begin
                  post_match(1'b1, held_offset[level], held_length[level], 1'b1);
                  break;
               end
               if (level_left[level] != 0) begin
                  level_dropped[level] = 1'b1;
                  break;
               end
            end else begin
               break;
            end
            held[level] = 1'b0;
            level_dropped[level] = 1'b0;
            level--;
            phase = PH_TAG1;
         end
         position++;
         if (!done && last) close_buffer();
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void compare_match(logic found, logic [15:0] offset, logic [15:0] length,
                                  logic comp);
         rsp_word_type want;
         if (awaited_matches.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result found=%0d offset=%0d length=%0d composite=%0d",
                     $time, found, offset, length, comp);
            return;
         end
         want = awaited_matches.pop_front();
         compare_field("found", 16'(want.found), 16'(found));
         compare_field("value_offset", want.value_offset, offset);
         compare_field("value_length", want.value_length, length);
         compare_field("matched_composite", 16'(want.matched_composite), 16'(comp));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   tlvts_req_if req_bus ();
   tlvts_rsp_if rsp_bus ();

   tlv_match_tracker tracker;
   logic [15:0]      search_tag;
   byte_queue_type   frame;
   int               word_count;
   bit               calm;
   bit               hold_request;

   tlv_tag_search_unit #(
      .MAX_DEPTH(DEPTH_LIMIT),
      .MAX_BUFFER_BYTES(BUFFER_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.compare_match(rsp_bus.found, rsp_bus.value_offset, rsp_bus.value_length,
                               rsp_bus.matched_composite);
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   initial begin
      #400_000;
      $display("tlv_tag_search_unit regression: fail");
      $finish;
   end

   function automatic byte_queue_type build_level(int chain, int budget);
      byte_queue_type out;
      byte_queue_type kid;
      logic [7:0]     b;
      logic [7:0]     s;
      logic [15:0]    len;
      bit             comp;
      int             count;
      count = (chain > 0) ? 1 : $urandom_range(1, 3);
      for (int i = 0; i < count && budget >= 2; i++) begin
         kid = {};
         if ($urandom_range(0, 4) == 0) begin
            if (search_tag[15:8] != 8'h00) begin
               out.push_back(search_tag[15:8]);
               out.push_back({1'($urandom_range(0, 1)), search_tag[6:0]});
               comp = search_tag[COMP_BIT_HI];
            end else begin
               out.push_back(search_tag[7:0]);
               comp = search_tag[COMP_BIT_LO];
            end
         end else begin
            comp = (chain > 0) || ($urandom_range(0, 2) == 0);
            b = 8'($urandom);
            b[COMP_BIT_LO] = comp;
            if ($urandom_range(0, 3) == 0) b[4:0] = TAG_EXT_CODE;
            out.push_back(b);
            if (b[4:0] == TAG_EXT_CODE) begin
               s = 8'($urandom);
               if (s[4:0] == TAG_EXT_CODE && $urandom_range(0, 19) != 0) s[0] = 1'b0;
               out.push_back(s);
            end
         end
         if (comp && budget > 4) begin
            kid = build_level((chain > 0) ? chain - 1 : 0,
                              (chain > 0) ? budget - 4 : $urandom_range(0, budget - 4));
            len = 16'(kid.size());
         end else begin
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 300))
                                               : 16'($urandom_range(0, 6));
            repeat (len) kid.push_back(8'($urandom));
         end
         if ($urandom_range(0, 11) == 0) begin
            len = (len >= 2) ? len + 16'($urandom_range(0, 4)) - 16'd2
                             : len + 16'($urandom_range(1, 2));
         end
         if (len < 16'd255 && $urandom_range(0, 5) != 0) begin
            out.push_back(len[7:0]);
         end else begin
            out.push_back(LEN_EXT_CODE);
            out.push_back(len[15:8]);
            out.push_back(len[7:0]);
         end
         out = {out, kid};
         budget -= 3 + kid.size();
      end
      return out;
   endfunction

   task automatic send_word(input logic [7:0] data, input bit first, input bit last);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.first_byte <= first;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_byte(data, first, last);
   endtask

   task automatic send_frame(input frame_kind_type kind);
      int cut;
      int mid;
      cut = frame.size();
      if (kind == FRAME_CUT) cut = $urandom_range(1, frame.size());
      mid = (cut > 1) ? $urandom_range(1, cut - 1) : 0;
      for (int i = 0; i < cut; i++) begin
         send_word(frame[i], i == 0 || (kind == FRAME_RESTART && i == mid),
                   i == cut - 1 && kind != FRAME_OPEN);
      end
      if (kind == FRAME_TRAIL) begin
         repeat ($urandom_range(1, 4)) send_word(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      end
      word_count += cut;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (tracker.awaited_matches.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_target(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.target = value;
      search_tag = value;
   endtask

   initial begin
      int             chain;
      int             budget;
      int             frames;
      frame_kind_type kind;
      tracker = new();
      calm = 1'b0;
      hold_request = 1'b0;
      word_count = 0;
      search_tag = '0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.first_byte <= 1'b0;
      req_bus.last_byte <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_target(16'h0000);
      frame = {8'h00, 8'h00};
      send_frame(FRAME_TRAIL);
      wait_drained();
      write_target(16'hffff);
      frame = {8'h1f, 8'hff};
      send_frame(FRAME_CLEAN);
      frame = {8'hff};
      send_frame(FRAME_CLEAN);
      wait_drained();
      write_target(16'h0021);
      frame = {8'h21, 8'h03, 8'h01, 8'h01, 8'haa};
      send_frame(FRAME_CLEAN);
      frame = {8'h21, 8'h05, 8'h21, 8'h00};
      send_frame(FRAME_CLEAN);
      wait_drained();
      write_target(16'h9f41);
      frame = {8'h9f, 8'hc1, 8'hff, 8'h00, 8'h03};
      send_frame(FRAME_CLEAN);
      frame = {8'h20, 8'h04, 8'h05, 8'h09, 8'haa, 8'hbb, 8'h9f, 8'h41, 8'h00};
      send_frame(FRAME_CLEAN);
      wait_drained();

      word_count = 0;
      for (int p = 0; word_count < RANDOM_WORDS; p++) begin
         case ($urandom_range(0, 5))
            0: write_target(16'h0000);
            1: write_target(16'hffff);
            2, 3: write_target({8'h00,
                                8'($urandom_range(0, 255)) & 8'hfe | 8'($urandom_range(0, 1))});
            4: write_target({8'($urandom) | {3'b000, TAG_EXT_CODE}, 1'b0, 7'($urandom) & 7'h7e});
            default: write_target(16'($urandom));
         endcase
         calm = (p == 4 || p == 5);
         if (p == 2) hold_request = 1'b1;
         frames = $urandom_range(4, 9);
         for (int f = 0; f < frames; f++) begin
            chain = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : 0;
            budget = (chain > 0) ? 60 : (($urandom_range(0, 9) == 0) ? 120 : $urandom_range(3, 30));
            frame = build_level(chain, budget);
            if (frame.size() == 0) frame.push_back(8'($urandom));
            kind = FRAME_CLEAN;
            if (f < frames - 1 && $urandom_range(0, 99) < 15) begin
               kind = frame_kind_type'($urandom_range(1, 4));
            end
            send_frame(kind);
         end
         wait_drained();
      end
      calm = 1'b0;

      if (tracker.mismatches == 0) begin
         $display("tlv_tag_search_unit regression: pass");
      end else begin
         $display("tlv_tag_search_unit regression: fail");
      end
      $finish;
   end
endmodule
